// ----- hw/rtl/brms_pkg.sv -----
// brms_pkg: shared types, widths and constants of the bucketed rms level block
`default_nettype none
package brms_pkg;

  // field and state widths
  localparam int SAMPLE_W = 32;
  localparam int MAG_W    = 16;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = 52;
  localparam int POS_W    = 18;
  localparam int CC_W     = 4;
  localparam int FMT_W    = 2;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 18;
  localparam int SCALE_W  = 10;
  localparam int NUM_W    = SUM_W + SCALE_W;
  localparam int CNT_W    = POS_W + CC_W;
  localparam int ROOT_W   = NUM_W / 2;
  localparam int STEP_W   = $clog2(NUM_W);
  localparam int LEVEL_W  = 15;
  localparam int LSHIFT   = 5;

  // full scale is 32768, so 100 * 256 * rms = sqrt(sum * 625 / count) / 32
  localparam logic [SCALE_W-1:0] SCALE     = SCALE_W'(625);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(25600);
  localparam logic [8:0]         U8_BIAS   = 9'd128;

  // register indexes on the configuration port
  localparam logic [CFG_A_W-1:0] REG_BUCKET_LENGTH = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_SAMPLE_FORMAT = 2'd2;

  // register reset values
  localparam logic [POS_W-1:0] BUCKET_RESET  = POS_W'(441);
  localparam logic [CC_W-1:0]  CHANNEL_RESET = CC_W'(1);

  // sample format codes
  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

  // controller states
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SQUARE = 8'b0000_0010,
    ST_ACCUM  = 8'b0000_0100,
    ST_COUNT  = 8'b0000_1000,
    ST_CHECK  = 8'b0001_0000,
    ST_DIV    = 8'b0010_0000,
    ST_SQRT   = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept_sample;
    logic accept_flush;
    logic square;
    logic accum;
    logic load_count;
    logic clear_bucket;
    logic div_start;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bucket_done;
    logic count_zero;
    logic step_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/brms_ctrl.sv -----
// brms_ctrl: sequencing state machine of the bucketed rms level block
`default_nettype none
module brms_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_flush,
  output logic                   in_ready,
  input  wire brms_pkg::status_t status,
  output brms_pkg::cmd_t         cmd
);

  brms_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == brms_pkg::ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      brms_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_flush) begin
            cmd.accept_flush = 1'b1;
            state_next       = brms_pkg::ST_COUNT;
          end else begin
            cmd.accept_sample = 1'b1;
            state_next        = brms_pkg::ST_SQUARE;
          end
        end
      end
      brms_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = brms_pkg::ST_ACCUM;
      end
      brms_pkg::ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = status.bucket_done ? brms_pkg::ST_COUNT : brms_pkg::ST_IDLE;
      end
      brms_pkg::ST_COUNT: begin
        cmd.load_count = 1'b1;
        state_next     = brms_pkg::ST_CHECK;
      end
      brms_pkg::ST_CHECK: begin
        // an empty bucket at a flush gives no level
        if (status.count_zero) begin
          state_next = brms_pkg::ST_IDLE;
        end else begin
          cmd.clear_bucket = 1'b1;
          cmd.div_start    = 1'b1;
          state_next       = brms_pkg::ST_DIV;
        end
      end
      brms_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.step_last) begin
          cmd.sqrt_start = 1'b1;
          state_next     = brms_pkg::ST_SQRT;
        end
      end
      brms_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.step_last) begin
          state_next = brms_pkg::ST_OUT;
        end
      end
      brms_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = brms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = brms_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/brms_dpath.sv -----
// brms_dpath: accumulator, divider, square root and output register
`default_nettype none
module brms_dpath #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_BUCKET   = 262143
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [brms_pkg::CFG_A_W-1:0]    cfg_addr,
  input  wire logic [brms_pkg::CFG_D_W-1:0]    cfg_data,
  input  wire logic [brms_pkg::SAMPLE_W-1:0]   sample_raw,
  input  wire brms_pkg::cmd_t                  cmd,
  output brms_pkg::status_t                    status,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [brms_pkg::LEVEL_W-1:0]         level_q8,
  output logic                                 partial_bucket
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [brms_pkg::CC_W-1:0]  MAX_CH_C = brms_pkg::CC_W'(MAX_CHANNELS);
  localparam logic [brms_pkg::POS_W-1:0] MAX_BK_C = brms_pkg::POS_W'(MAX_BUCKET);

  // configuration registers
  logic [brms_pkg::POS_W-1:0] bucket_length;
  logic [brms_pkg::CC_W-1:0]  channel_count;
  logic [brms_pkg::FMT_W-1:0] sample_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_length <= brms_pkg::BUCKET_RESET;
      channel_count <= brms_pkg::CHANNEL_RESET;
      sample_format <= brms_pkg::FMT_S16;
    end else if (cfg_we) begin
      case (cfg_addr)
        brms_pkg::REG_BUCKET_LENGTH: bucket_length <= cfg_data;
        brms_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[brms_pkg::CC_W-1:0];
        brms_pkg::REG_SAMPLE_FORMAT: sample_format <= cfg_data[brms_pkg::FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped register values
  logic [brms_pkg::CC_W-1:0]  eff_ch;
  logic [brms_pkg::POS_W-1:0] eff_bucket;

  always_comb begin
    if (channel_count == '0) begin
      eff_ch = brms_pkg::CC_W'(1);
    end else if (channel_count > MAX_CH_C) begin
      eff_ch = MAX_CH_C;
    end else begin
      eff_ch = channel_count;
    end
    if (bucket_length == '0) begin
      eff_bucket = brms_pkg::POS_W'(1);
    end else if (bucket_length > MAX_BK_C) begin
      eff_bucket = MAX_BK_C;
    end else begin
      eff_bucket = bucket_length;
    end
  end

  // sample normalisation to a 16-bit magnitude
  logic [8:0]                 u8_diff;
  logic [brms_pkg::MAG_W-1:0] word;
  logic [brms_pkg::MAG_W-1:0] mag_in;

  always_comb begin
    u8_diff = {1'b0, sample_raw[7:0]} - brms_pkg::U8_BIAS;
    word    = sample_raw[15:0];
    mag_in  = '0;
    case (sample_format)
      brms_pkg::FMT_U8: begin
        mag_in = {(u8_diff[8] ? (~u8_diff[7:0] + 8'd1) : u8_diff[7:0]), 8'd0};
      end
      brms_pkg::FMT_S32: begin
        word   = sample_raw[31:16];
        mag_in = word[15] ? (~word + 16'd1) : word;
      end
      default: begin
        mag_in = word[15] ? (~word + 16'd1) : word;
      end
    endcase
  end

  // magnitude and square registers, partial flag
  logic [brms_pkg::MAG_W-1:0] mag;
  logic [brms_pkg::SQ_W-1:0]  square;
  logic                       partial;

  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      mag     <= mag_in;
      partial <= 1'b0;
    end
    if (cmd.accept_flush) begin
      partial <= 1'b1;
    end
    if (cmd.square) begin
      square <= brms_pkg::SQ_W'(mag) * brms_pkg::SQ_W'(mag);
    end
  end

  // bucket state
  logic [brms_pkg::SUM_W-1:0] square_sum;
  logic [brms_pkg::POS_W-1:0] positions_filled;
  logic [CH_W-1:0]            channel_index;
  logic [brms_pkg::POS_W-1:0] pos_inc;
  logic                       pos_done;

  assign pos_inc  = positions_filled + brms_pkg::POS_W'(1);
  assign pos_done = ({1'b0, brms_pkg::CC_W'(channel_index)} + 5'd1) >= {1'b0, eff_ch};
  assign status.bucket_done = pos_done && (pos_inc >= eff_bucket);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_bucket) begin
      square_sum       <= '0;
      positions_filled <= '0;
      channel_index    <= '0;
    end else if (cmd.accum) begin
      square_sum <= square_sum + brms_pkg::SUM_W'(square);
      if (pos_done) begin
        channel_index    <= '0;
        positions_filled <= pos_inc;
      end else begin
        channel_index <= channel_index + CH_W'(1);
      end
    end
  end

  // sample count and scaled numerator
  logic [brms_pkg::CNT_W-1:0] count;
  logic [brms_pkg::NUM_W-1:0] numer;

  always_ff @(posedge clk) begin
    if (cmd.load_count) begin
      count <= (brms_pkg::CNT_W'(positions_filled) * brms_pkg::CNT_W'(eff_ch))
               + brms_pkg::CNT_W'(channel_index);
      numer <= brms_pkg::NUM_W'(square_sum) * brms_pkg::NUM_W'(brms_pkg::SCALE);
    end
  end

  assign status.count_zero = (count == '0);

  // shared step counter for divider and square root
  logic [brms_pkg::STEP_W-1:0] step;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      step <= brms_pkg::STEP_W'(brms_pkg::NUM_W - 1);
    end else if (cmd.sqrt_start) begin
      step <= brms_pkg::STEP_W'(brms_pkg::ROOT_W - 1);
    end else if (cmd.div_step || cmd.sqrt_step) begin
      step <= step - brms_pkg::STEP_W'(1);
    end
  end

  assign status.step_last = (step == '0);

  // restoring divider, one quotient bit a cycle; quotient ends in dq
  logic [brms_pkg::NUM_W-1:0] dq;
  logic [brms_pkg::CNT_W-1:0] drem;
  logic [brms_pkg::CNT_W:0]   drem_sh;
  logic                       dbit;

  assign drem_sh = {drem, dq[brms_pkg::NUM_W-1]};
  assign dbit    = (drem_sh >= {1'b0, count});

  // digit-by-digit square root; each step sets one root bit
  localparam int SREM_W = brms_pkg::ROOT_W + 2;
  logic [brms_pkg::ROOT_W-1:0] root;
  logic [SREM_W-1:0]           srem;
  logic [SREM_W+1:0]           srem_sh;
  logic [SREM_W+1:0]           trial;
  logic                        sbit;

  assign srem_sh = {srem, dq[brms_pkg::NUM_W-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign sbit    = (srem_sh >= trial);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq   <= numer;
      drem <= '0;
    end else if (cmd.div_step) begin
      dq   <= {dq[brms_pkg::NUM_W-2:0], dbit};
      drem <= dbit ? brms_pkg::CNT_W'(drem_sh - {1'b0, count})
                   : drem_sh[brms_pkg::CNT_W-1:0];
    end else if (cmd.sqrt_step) begin
      dq <= {dq[brms_pkg::NUM_W-3:0], 2'b00};
    end
    if (cmd.sqrt_start) begin
      root <= '0;
      srem <= '0;
    end else if (cmd.sqrt_step) begin
      root <= {root[brms_pkg::ROOT_W-2:0], sbit};
      srem <= sbit ? SREM_W'(srem_sh - trial) : srem_sh[SREM_W-1:0];
    end
  end

  // level scaling and saturation
  localparam int LV_W = brms_pkg::ROOT_W - brms_pkg::LSHIFT;
  logic [LV_W-1:0]              level_full;
  logic [brms_pkg::LEVEL_W-1:0] level_sat;

  assign level_full = root[brms_pkg::ROOT_W-1:brms_pkg::LSHIFT];
  assign level_sat  = (level_full > LV_W'(brms_pkg::LEVEL_MAX))
                      ? brms_pkg::LEVEL_MAX : level_full[brms_pkg::LEVEL_W-1:0];

  // output register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      level_q8       <= level_sat;
      partial_bucket <= partial;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bucketed_rms_level.sv -----
// bucketed_rms_level: top level of the windowed rms envelope block
//
//   channel   signals                          carries
//   s_*       s_tvalid s_tready s_tdata s_tuser  one sample or a flush mark
//   m_*       m_tvalid m_tready m_tdata m_tuser  one bucket level
//   cfg_*     cfg_we cfg_addr cfg_data          register writes, no read-back
//
// a sample passes through capture, square and accumulate before the next is taken.
// a level follows the sample that ends its bucket, or a flush, through the count and
// check steps, the restoring divider and the square root unit; one shared
// step counter drives both; no input is taken while they run.
// a waiting level does not block samples that complete no bucket; the next level
// holds in the sequencer until the output register is free.
// rst is synchronous and clears the bucket and registers to their reset values.
`default_nettype none
module bucketed_rms_level #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_BUCKET   = 262143
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [31:0]                    s_tdata,   // [31:0] sample_raw
  input  wire logic                           s_tuser,   // [0] flush
  // output stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [15:0]                         m_tdata,   // [14:0] level_q8, [15] zero
  output logic                                m_tuser,   // [0] partial_bucket
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [brms_pkg::CFG_A_W-1:0]   cfg_addr,
  input  wire logic [brms_pkg::CFG_D_W-1:0]   cfg_data
);

  brms_pkg::cmd_t               cmd;
  brms_pkg::status_t            status;
  logic [brms_pkg::LEVEL_W-1:0] level_q8;

  // sequencer
  brms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_flush (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  brms_dpath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_BUCKET   (MAX_BUCKET)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .sample_raw     (s_tdata),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .level_q8       (level_q8),
    .partial_bucket (m_tuser)
  );

  assign m_tdata = {1'b0, level_q8};

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// tb: stream testbench for the bucketed rms level block with its own level predictor
`timescale 1ns / 100ps
module tb;

  localparam int MAX_CH = 8;
  localparam int LEVEL_LATENCY = 120;
  localparam logic [brms_pkg::CFG_A_W-1:0] REG_UNUSED = 2'd3;

  // expected level as it leaves the block
  typedef struct packed {
    logic [brms_pkg::LEVEL_W-1:0] level;
    logic                         partial;
  } level_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [brms_pkg::CFG_A_W-1:0] cfg_addr = '0;
  logic [brms_pkg::CFG_D_W-1:0] cfg_data = '0;

  // predictor copy of registers and bucket state
  logic [brms_pkg::POS_W-1:0] reg_bucket;
  logic [brms_pkg::CC_W-1:0]  reg_chans;
  logic [brms_pkg::FMT_W-1:0] reg_fmt;
  logic [brms_pkg::SUM_W-1:0] acc_sum;
  int                         acc_pos;
  int                         acc_ch;

  level_t level_q[$];
  int errors = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  bucketed_rms_level uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // bit-by-bit integer square root
  function automatic logic [31:0] int_sqrt(input logic [63:0] x);
    logic [31:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = {32'b0, r | (32'h1 << b)};
      if (t * t <= x) r = r | (32'h1 << b);
    end
    return r;
  endfunction

  // rms level of the current sum over count samples, saturated
  function automatic logic [brms_pkg::LEVEL_W-1:0] bucket_level(input longint count);
    logic [63:0] quo;
    logic [31:0] rt;
    quo = (64'(acc_sum) * 64'(brms_pkg::SCALE)) / 64'(count);
    rt = int_sqrt(quo) >> brms_pkg::LSHIFT;
    if (rt > 32'(brms_pkg::LEVEL_MAX)) return brms_pkg::LEVEL_MAX;
    return rt[brms_pkg::LEVEL_W-1:0];
  endfunction

  // magnitude of the normalised sample, 0..32768
  function automatic longint sample_mag(input logic [31:0] raw);
    int v;
    case (reg_fmt)
      brms_pkg::FMT_U8:  v = (int'(raw[7:0]) - int'(brms_pkg::U8_BIAS)) * 256;
      brms_pkg::FMT_S32: v = int'($signed(raw[31:16]));
      default:           v = int'($signed(raw[15:0]));
    endcase
    return longint'(v < 0 ? -v : v);
  endfunction

  function automatic int eff_chans();
    if (reg_chans == 0) return 1;
    if (int'(reg_chans) > MAX_CH) return MAX_CH;
    return int'(reg_chans);
  endfunction

  task automatic clear_bucket();
    acc_sum = '0;
    acc_pos = 0;
    acc_ch = 0;
  endtask

  // advance the predictor by one accepted transaction
  task automatic predict_item(input logic [31:0] raw, input logic fl);
    int ch;
    int bl;
    longint m;
    longint count;
    level_t lv;
    ch = eff_chans();
    bl = (reg_bucket == 0) ? 1 : int'(reg_bucket);
    if (fl) begin
      count = longint'(acc_pos) * ch + acc_ch;
      if (count != 0) begin
        lv.level = bucket_level(count);
        lv.partial = 1'b1;
        level_q.push_back(lv);
        clear_bucket();
      end
    end else begin
      m = sample_mag(raw);
      acc_sum = acc_sum + brms_pkg::SUM_W'(m * m);
      if (acc_ch + 1 >= ch) begin
        acc_ch = 0;
        acc_pos = (acc_pos + 1) % (1 << brms_pkg::POS_W);
        if (acc_pos >= bl) begin
          lv.level = bucket_level(longint'(acc_pos) * ch);
          lv.partial = 1'b0;
          level_q.push_back(lv);
          clear_bucket();
        end
      end else begin
        acc_ch = acc_ch + 1;
      end
    end
  endtask

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(input logic [31:0] raw, input logic fl);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle_pct) gap++;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= raw;
    s_tuser <= fl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(raw, fl);
  endtask

  task automatic write_reg(input logic [brms_pkg::CFG_A_W-1:0] idx,
                           input logic [brms_pkg::CFG_D_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      brms_pkg::REG_BUCKET_LENGTH: reg_bucket = val[brms_pkg::POS_W-1:0];
      brms_pkg::REG_CHANNEL_COUNT: reg_chans = val[brms_pkg::CC_W-1:0];
      brms_pkg::REG_SAMPLE_FORMAT: reg_fmt = val[brms_pkg::FMT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold the sender until every expected level has come
  task automatic hold_until_empty();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    hold_until_empty();
    repeat (LEVEL_LATENCY) @(posedge clk);
  endtask

  // compare each output transaction with the oldest expected level
  always @(posedge clk) begin : check_levels
    level_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (level_q.size() == 0) begin
        errors++;
        $display("%0t unexpected level: expected none, actual tdata %h tuser %b",
                 $time, m_tdata, m_tuser);
      end else begin
        want = level_q.pop_front();
        if (m_tdata !== {1'b0, want.level}) begin
          errors++;
          $display("%0t level mismatch: expected %0d, actual tdata %h",
                   $time, want.level, m_tdata);
        end
        if (m_tuser !== want.partial) begin
          errors++;
          $display("%0t partial flag mismatch: expected %b, actual %b",
                   $time, want.partial, m_tuser);
        end
      end
    end
  end

  // reset values, empty flush, then a short partial bucket
  task automatic test_reset_defaults();
    send_item($urandom, 1'b1);
    send_item(32'h0000_8000, 1'b0);
    send_item(32'hFFFF_7FFF, 1'b0);
    send_item(32'h0000_1234, 1'b0);
    send_item(32'h0, 1'b1);
    drain();
  endtask

  // every format at its extremes, bits outside the format set
  task automatic test_formats();
    write_reg(brms_pkg::REG_BUCKET_LENGTH, 18'd1);
    write_reg(brms_pkg::REG_SAMPLE_FORMAT, brms_pkg::CFG_D_W'(brms_pkg::FMT_U8));
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_00FF, 1'b0);
    send_item(32'hFFFF_FF80, 1'b0);
    drain();
    // zero bucket length counts as one
    write_reg(brms_pkg::REG_BUCKET_LENGTH, 18'd0);
    write_reg(brms_pkg::REG_SAMPLE_FORMAT, brms_pkg::CFG_D_W'(brms_pkg::FMT_S16));
    send_item(32'hFFFF_8000, 1'b0);
    send_item(32'h0000_7FFF, 1'b0);
    drain();
    write_reg(brms_pkg::REG_SAMPLE_FORMAT, brms_pkg::CFG_D_W'(brms_pkg::FMT_S32));
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h0000_FFFF, 1'b0);
    drain();
    // unused format code behaves as s16
    write_reg(brms_pkg::REG_SAMPLE_FORMAT,
              brms_pkg::CFG_D_W'({brms_pkg::FMT_S32 | brms_pkg::FMT_S16}));
    send_item(32'h0000_8000, 1'b0);
    drain();
  endtask

  // flush inside an unfinished position
  task automatic test_channels();
    write_reg(brms_pkg::REG_CHANNEL_COUNT, 18'd3);
    write_reg(brms_pkg::REG_BUCKET_LENGTH, 18'd2);
    send_item(32'h0000_4000, 1'b0);
    send_item(32'h0000_C000, 1'b0);
    send_item(32'h0, 1'b1);
    drain();
  endtask

  // channel count lowered mid-bucket drives the level into saturation
  task automatic test_mid_bucket_change();
    write_reg(brms_pkg::REG_CHANNEL_COUNT, 18'd4);
    write_reg(brms_pkg::REG_BUCKET_LENGTH, 18'd4);
    repeat (4) send_item(32'h0000_8000, 1'b0);
    drain();
    write_reg(brms_pkg::REG_CHANNEL_COUNT, 18'd1);
    repeat (3) send_item(32'h0000_8000, 1'b0);
    drain();
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(5))
      0: return 32'h8000_8000;
      1: return 32'h7FFF_7FFF;
      2: return 32'(($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF_FFFF);
      3: return 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  // random streams over many register settings and idling modes
  task automatic test_random_streams();
    int r;
    int n;
    logic big;
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      big = (ph == 7 || ph == 18);
      r = $urandom_range(9);
      if (big) write_reg(brms_pkg::REG_BUCKET_LENGTH, 18'h3FFFF);
      else if (r == 0) write_reg(brms_pkg::REG_BUCKET_LENGTH, 18'd0);
      else if (r < 7) write_reg(brms_pkg::REG_BUCKET_LENGTH, 18'($urandom_range(1, 6)));
      else write_reg(brms_pkg::REG_BUCKET_LENGTH, 18'($urandom_range(7, 40)));
      write_reg(brms_pkg::REG_CHANNEL_COUNT, {14'($urandom), 4'($urandom_range(15))});
      write_reg(brms_pkg::REG_SAMPLE_FORMAT, {16'($urandom), 2'($urandom_range(3))});
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 18'($urandom));
      n = 40 + $urandom_range(10);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(29) == 0) send_item($urandom, 1'b1);
        else send_item(pick_sample(), 1'b0);
        if (k == n / 2 && $urandom_range(2) == 0) hold_until_empty();
      end
      if (big || $urandom_range(2) == 0) send_item($urandom, 1'b1);
      drain();
    end
  endtask

  initial begin
    reg_bucket = brms_pkg::BUCKET_RESET;
    reg_chans = brms_pkg::CHANNEL_RESET;
    reg_fmt = brms_pkg::FMT_S16;
    clear_bucket();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_formats();
    test_channels();
    test_mid_bucket_change();
    test_random_streams();
    if (errors == 0) begin
      $display("PASS bucketed_rms_level");
    end else begin
      $display("FAIL bucketed_rms_level");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL bucketed_rms_level");
    $finish;
  end

endmodule
